>>> hdl/prwd_pkg.sv
// shared types and constants of the pose repeat window detector
// no dependencies; compiled first
package prwd_pkg;

  // pose component format and count
  localparam int DATA_W = 32;
  localparam int COMP_N = 6;

  // default window depth
  localparam int DEFAULT_DEPTH = 8;

  // drain cycles after the scan ends, until the last hit reaches the accumulator
  localparam int DRAIN_CYC = 3;
  localparam int DRAIN_W   = $clog2(DRAIN_CYC);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // compare result handed from the merge stage to the sequencer
  typedef struct packed {
    logic hit_valid;
    logic hit;
  } merge_status_t;

endpackage

>>> hdl/prwd_if.sv
// handshake channels of the pose repeat window detector
// depends on prwd_pkg
interface prwd_pose_if import prwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] roll;
  logic [DATA_W-1:0] pitch;
  logic [DATA_W-1:0] yaw;
  logic [DATA_W-1:0] pos_x;
  logic [DATA_W-1:0] pos_y;
  logic [DATA_W-1:0] pos_z;

  modport source (output valid, roll, pitch, yaw, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, roll, pitch, yaw, pos_x, pos_y, pos_z, output ready);
endinterface

interface prwd_stop_if;
  logic valid;
  logic ready;
  logic stop;

  modport source (output valid, stop, input ready);
  modport sink (input valid, stop, output ready);
endinterface

>>> hdl/pose_repeat_window_detector_unit.sv
// top level of the pose repeat window detector
// depends on prwd_pkg, prwd_if, prwd_lane and prwd_merge
//
// Usage:
//   pose    - input channel, one six-component Q16.16 pose per item
//   result  - output channel, one stop flag per item
//   cfg_wr_en / cfg_wr_data - write of change_limit, taken on any edge with
//             cfg_wr_en high; write only while the block is idle
// Each pose is compared with the stored window, one stored pose per cycle:
// six lanes form the component differences in parallel and the merge stage
// sums and compares them. The time from accept to result grows with the fill
// count, since the scan reads the stored poses from the window ram in turn.
// One item is in work at a time: the next pose is taken only once the last
// one's result has been written.
// After the compare the pose is written to the window in ring order.
// Reset empties the window (fill count zero) and clears change_limit.
// The result waits in an output register; a new pose is accepted meanwhile,
// and its scan runs, but it finishes only once the waiting result is taken.
module pose_repeat_window_detector_unit import prwd_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  prwd_pose_if.sink         pose,
  prwd_stop_if.source       result,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t              state;
  state_t              state_next;
  logic [DATA_W-1:0]   change_limit;
  logic [DATA_W-1:0]   comp [COMP_N];
  logic [CW-1:0]       fill_count;
  logic [CW-1:0]       scan_idx;
  logic [AW-1:0]       wr_pos;
  logic [DRAIN_W-1:0]  drain_cnt;
  logic                hit_acc;
  logic                out_valid;
  logic                out_stop;

  logic                accept;
  logic                rd_en;
  logic                wr_en;
  logic                scan_start;
  logic                drain_start;

  logic [COMP_N-1:0]   lane_valid;
  logic [DATA_W-1:0]   mag [COMP_N];
  merge_status_t       merge_status;

  assign accept        = pose.valid && pose.ready;
  assign pose.ready    = (state == ST_IDLE);
  assign result.valid  = out_valid;
  assign result.stop   = out_stop;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      change_limit <= '0;
    end else if (cfg_wr_en) begin
      change_limit <= cfg_wr_data;
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_next  = state;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    scan_start  = 1'b0;
    drain_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          scan_start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx < fill_count) begin
          rd_en = 1'b1;
        end else begin
          drain_start = 1'b1;
          state_next  = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == DRAIN_W'(DRAIN_CYC - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          wr_en      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // latched pose, held through the scan and the write
  always_ff @(posedge clk) begin
    if (accept) begin
      comp[0] <= pose.roll;
      comp[1] <= pose.pitch;
      comp[2] <= pose.yaw;
      comp[3] <= pose.pos_x;
      comp[4] <= pose.pos_y;
      comp[5] <= pose.pos_z;
    end
  end

  // scan index, drain counter and hit accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      drain_cnt <= '0;
      hit_acc   <= 1'b0;
    end else begin
      if (scan_start) begin
        scan_idx <= '0;
      end else if (rd_en) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (drain_start) begin
        drain_cnt <= '0;
      end else if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt + DRAIN_W'(1);
      end
      if (scan_start) begin
        hit_acc <= 1'b0;
      end else if (merge_status.hit_valid && merge_status.hit) begin
        hit_acc <= 1'b1;
      end
    end
  end

  // window ring position and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos     <= '0;
      fill_count <= '0;
    end else if (wr_en) begin
      wr_pos <= (wr_pos == AW'(DEPTH - 1)) ? '0 : wr_pos + AW'(1);
      if (fill_count < CW'(DEPTH)) begin
        fill_count <= fill_count + CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_en) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_stop <= hit_acc;
    end
  end

  // one lane per pose component
  for (genvar g = 0; g < COMP_N; g++) begin : g_lane
    prwd_lane #(
      .DEPTH(DEPTH)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_addr  (wr_pos),
      .wr_data  (comp[g]),
      .rd_en    (rd_en),
      .rd_addr  (scan_idx[AW-1:0]),
      .comp     (comp[g]),
      .mag_valid(lane_valid[g]),
      .mag      (mag[g])
    );
  end

  // sum, saturate and compare
  prwd_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .lane_valid  (lane_valid),
    .mag         (mag),
    .change_limit(change_limit),
    .status      (merge_status)
  );

  // window never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(DEPTH))
    else $error("fill count beyond window depth");

  // only written entries are read
  a_read_written: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> scan_idx < fill_count)
    else $error("read of an entry beyond the fill count");

  // the new pose is stored only after every compare has landed
  a_write_after_drain: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !merge_status.hit_valid && !(|lane_valid))
    else $error("window write while compares still in flight");

  // a result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    wr_en && out_valid |-> result.ready)
    else $error("pending result overwritten");

  // an accepted pose starts a scan from the first entry
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN && scan_idx == '0)
    else $error("scan did not start after accept");

endmodule

>>> hdl/prwd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module prwd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/prwd_lane.sv
// one component lane: history ram and absolute difference against the new pose
// depends on prwd_pkg and prwd_ram
module prwd_lane import prwd_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic [DATA_W-1:0] comp,
  output logic              mag_valid,
  output logic [DATA_W-1:0] mag
);

  logic [DATA_W-1:0] hist;
  logic              rd_valid;
  logic [DATA_W:0]   diff;
  logic [DATA_W:0]   diff_neg;

  prwd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(hist)
  );

  // exact signed difference, magnitude always fits in DATA_W bits
  always_comb begin
    diff     = {comp[DATA_W-1], comp} - {hist[DATA_W-1], hist};
    diff_neg = (DATA_W+1)'(0) - diff;
  end

  // valid tracking of the read and magnitude stages
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mag_valid <= 1'b0;
    end else begin
      rd_valid  <= rd_en;
      mag_valid <= rd_valid;
    end
  end

  // magnitude register
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      mag <= diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];
    end
  end

endmodule

>>> hdl/prwd_merge.sv
// merge stage: sums the lane magnitudes with saturation and compares to the limit
// depends on prwd_pkg
module prwd_merge import prwd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [COMP_N-1:0]   lane_valid,
  input  logic [DATA_W-1:0]   mag [COMP_N],
  input  logic [DATA_W-1:0]   change_limit,
  output merge_status_t       status
);

  localparam int PAIR_N = COMP_N / 2;
  localparam int SUM_W  = DATA_W + 3;

  logic [DATA_W:0]   pair_sum [PAIR_N];
  logic              pair_valid;
  logic [SUM_W-1:0]  total;
  logic [DATA_W-1:0] capped;

  // first level: pairwise sums
  always_ff @(posedge clk) begin
    for (int i = 0; i < PAIR_N; i++) begin
      pair_sum[i] <= {1'b0, mag[2*i]} + {1'b0, mag[2*i+1]};
    end
  end

  // second level: total, saturate, compare
  always_comb begin
    total = '0;
    for (int i = 0; i < PAIR_N; i++) begin
      total = total + SUM_W'(pair_sum[i]);
    end
    capped = (|total[SUM_W-1:DATA_W]) ? '1 : total[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      status     <= '0;
    end else begin
      pair_valid       <= &lane_valid;
      status.hit_valid <= pair_valid;
      status.hit       <= (capped <= change_limit);
    end
  end

endmodule

>>> tb/prwd_stop_checker.sv
`timescale 1ns / 100ps
// scoreboard for the pose repeat window detector: watches the pose, stop and limit ports
// keeps its own copy of the pose window and checks every stop item in order
// depends on prwd_pkg
module prwd_stop_checker import prwd_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pose_valid,
  input  logic                           pose_ready,
  input  logic [COMP_N-1:0][DATA_W-1:0]  pose_data,
  input  logic                           stop_valid,
  input  logic                           stop_ready,
  input  logic                           stop,
  input  logic                           cfg_wr_en,
  input  logic [DATA_W-1:0]              cfg_wr_data,
  output int                             checked_n,
  output int                             stop_n,
  output int                             fail_n
);

  typedef logic [COMP_N-1:0][DATA_W-1:0] pose_t;

  localparam int EXP_N = 16;

  // shadow of the window ring and the limit register
  pose_t             window [DEPTH];
  int unsigned       window_fill;
  int unsigned       window_wr;
  logic [DATA_W-1:0] change_limit;

  // ring of predicted stop items, oldest at exp_rd
  bit                expected_stops [EXP_N];
  int unsigned       exp_wr;
  int unsigned       exp_rd;

  // saturating sum of absolute component differences, differences taken at 33 bits
  function automatic logic [DATA_W-1:0] l1_distance(input pose_t a, input pose_t b);
    logic [DATA_W:0]   diff;
    logic [DATA_W:0]   mag;
    logic [DATA_W+1:0] sum;
    logic [DATA_W-1:0] acc;
    acc = '0;
    for (int c = 0; c < COMP_N; c++) begin
      diff = {a[c][DATA_W-1], a[c]} - {b[c][DATA_W-1], b[c]};
      mag  = diff[DATA_W] ? -diff : diff;
      sum  = {2'b00, acc} + {1'b0, mag};
      acc  = (sum > {2'b00, {DATA_W{1'b1}}}) ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
    end
    return acc;
  endfunction

  // any written entry within the limit
  function automatic bit window_hit(input pose_t p);
    for (int i = 0; i < window_fill; i++) begin
      if (l1_distance(p, window[i]) <= change_limit) return 1'b1;
    end
    return 1'b0;
  endfunction

  // track limit writes and poses, compare each stop item with the oldest prediction
  always @(posedge clk) begin
    bit want;
    if (rst) begin
      window_fill  = 0;
      window_wr    = 0;
      change_limit = '0;
      exp_wr       = 0;
      exp_rd       = 0;
      checked_n <= 0;
      stop_n    <= 0;
      fail_n    <= 0;
    end else begin
      if (cfg_wr_en) change_limit = cfg_wr_data;
      if (pose_valid && pose_ready) begin
        expected_stops[exp_wr % EXP_N] = window_hit(pose_data);
        exp_wr++;
        window[window_wr] = pose_data;
        window_wr = (window_wr + 1 == DEPTH) ? 0 : window_wr + 1;
        if (window_fill < DEPTH) window_fill++;
      end
      if (stop_valid && stop_ready) begin
        checked_n <= checked_n + 1;
        if (stop) stop_n <= stop_n + 1;
        if (exp_wr == exp_rd) begin
          $display("%0t: stop item with nothing expected, expected none actual stop=%b",
                   $time, stop);
          fail_n <= fail_n + 1;
        end else begin
          want = expected_stops[exp_rd % EXP_N];
          exp_rd++;
          if (stop !== want) begin
            $display("%0t: stop mismatch, expected %b actual %b", $time, want, stop);
            fail_n <= fail_n + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/pose_repeat_window_detector_unit_tb.sv
`timescale 1ns / 100ps
// stimulus and verdict for pose_repeat_window_detector_unit
// depends on prwd_pkg, prwd_if, the block itself and prwd_stop_checker
module pose_repeat_window_detector_unit_tb import prwd_pkg::*; ();

  typedef logic [COMP_N-1:0][DATA_W-1:0] pose_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [DATA_W-1:0] cfg_wr_data;

  int checked_n;
  int stop_n;
  int fail_n;
  int sent_n = 0;
  int limits_n = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  // recently sent poses, used to build near repeats
  pose_t recent [8];
  int    recent_n = 0;
  int    recent_wr = 0;

  prwd_pose_if pose_ch ();
  prwd_stop_if stop_ch ();

  pose_repeat_window_detector_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .pose        (pose_ch),
    .result      (stop_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  prwd_stop_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .pose_valid  (pose_ch.valid),
    .pose_ready  (pose_ch.ready),
    .pose_data   ({pose_ch.pos_z, pose_ch.pos_y, pose_ch.pos_x,
                   pose_ch.yaw, pose_ch.pitch, pose_ch.roll}),
    .stop_valid  (stop_ch.valid),
    .stop_ready  (stop_ch.ready),
    .stop        (stop_ch.stop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .checked_n   (checked_n),
    .stop_n      (stop_n),
    .fail_n      (fail_n)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_pct == 0) begin
      stop_ch.ready <= 1'b1;
    end else begin
      stop_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // hard stop on a hung run
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  function automatic pose_t flat_pose(input logic [DATA_W-1:0] v);
    pose_t p;
    for (int c = 0; c < COMP_N; c++) p[c] = v;
    return p;
  endfunction

  // mostly near or exact repeats of recent poses, some wide random poses
  function automatic pose_t random_pose();
    pose_t             p;
    int                pick;
    int                shift;
    logic [DATA_W-1:0] delta;
    pick = $urandom_range(99);
    if (recent_n == 0 || pick < 20) begin
      for (int c = 0; c < COMP_N; c++) begin
        case ($urandom_range(7))
          0: p[c] = 32'h8000_0000;
          1: p[c] = 32'h7FFF_FFFF;
          2: p[c] = '0;
          3: p[c] = '1;
          default: p[c] = $urandom;
        endcase
      end
    end else begin
      p = recent[$urandom_range(recent_n - 1)];
      if (pick >= 35) begin
        for (int c = 0; c < COMP_N; c++) begin
          if ($urandom_range(2) != 0) begin
            shift = $urandom_range(18);
            delta = $urandom & ((32'd1 << shift) - 1);
            p[c] = $urandom_range(1) ? p[c] + delta : p[c] - delta;
          end
        end
      end
    end
    return p;
  endfunction

  // hold off new poses until every stop item has been taken
  task automatic wait_drained();
    pose_ch.valid <= 1'b0;
    while (checked_n != sent_n) @(posedge clk);
  endtask

  task automatic write_limit(input logic [DATA_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limits_n++;
  endtask

  // offer one pose item, with random idle cycles ahead of it
  task automatic send_pose(input pose_t p);
    while ($urandom_range(99) < idle_pct) begin
      pose_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pose_ch.valid <= 1'b1;
    pose_ch.roll  <= p[0];
    pose_ch.pitch <= p[1];
    pose_ch.yaw   <= p[2];
    pose_ch.pos_x <= p[3];
    pose_ch.pos_y <= p[4];
    pose_ch.pos_z <= p[5];
    @(posedge clk);
    while (!pose_ch.ready) @(posedge clk);
    sent_n++;
    recent[recent_wr] = p;
    recent_wr = (recent_wr + 1) % 8;
    if (recent_n < 8) recent_n++;
  endtask

  initial begin
    pose_t p;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    pose_ch.valid <= 1'b0;
    pose_ch.roll  <= '0;
    pose_ch.pitch <= '0;
    pose_ch.yaw   <= '0;
    pose_ch.pos_x <= '0;
    pose_ch.pos_y <= '0;
    pose_ch.pos_z <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limit of zero: empty window, saturated distance, exact repeat
    send_pose(flat_pose(32'h8000_0000));
    send_pose(flat_pose(32'h7FFF_FFFF));
    send_pose(flat_pose(32'h7FFF_FFFF));
    send_pose(flat_pose(32'h0000_0000));
    send_pose(flat_pose(32'hFFFF_FFFF));

    // window wrap: the oldest pose is dropped, a newer one still matches
    write_limit(32'h0);
    for (int k = 1; k <= 9; k++) begin
      p = flat_pose(32'h0);
      p[0] = k << 16;
      send_pose(p);
    end
    p = flat_pose(32'h0);
    p[0] = 1 << 16;
    send_pose(p);
    p[0] = 3 << 16;
    send_pose(p);

    // full-scale limit: even a saturated distance matches
    write_limit(32'hFFFF_FFFF);
    send_pose(flat_pose(32'h8000_0000));
    send_pose(flat_pose(32'h7FFF_FFFF));

    // distance exactly at the limit, then one past it, across zero
    write_limit(32'd6);
    send_pose(flat_pose(32'hFFFF_FFFE));
    send_pose(flat_pose(32'hFFFF_FFFF));
    write_limit(32'd5);
    send_pose(flat_pose(32'h0000_0000));

    // random rounds, cycling through idle patterns and limit styles
    for (int round = 0; round < 8; round++) begin
      case ((round + round / 4) % 4)
        0: write_limit($urandom_range(32'h3FFFF, 0));
        1: write_limit(32'h0);
        2: write_limit(32'hFFFF_FFFF);
        default: write_limit($urandom);
      endcase
      case (round % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 62;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 62;
        end
        default: begin
          idle_pct = 14;
          stall_pct <= 14;
        end
      endcase
      for (int n = 0; n < 50; n++) begin
        send_pose(random_pose());
        if ($urandom_range(39) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    $display("summary: %0d poses over %0d limit settings, %0d stop items checked, %0d stops",
             sent_n, limits_n, checked_n, stop_n);
    if (fail_n == 0 && checked_n == sent_n) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
